FILE: rtl/core/rgbhsv_pkg.sv
// Shared types and constants for the 8-bit RGB to HSV pipeline.
// No dependencies; used by rgbhsv_div and rgb_to_hsv_8bit_core.
package rgbhsv_pkg;

    // Pixel channel width and divider numerator width
    localparam int PIX_W          = 8;
    localparam int NUM_W          = 2 * PIX_W;

    // Divider is cut into this many register stages
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = PIX_W / DIV_STAGES;

    // Arithmetic constants of the conversion
    localparam logic [PIX_W-1:0] SAT_SCALE  = 8'd255;
    localparam logic [PIX_W-1:0] HUE_GAIN   = 8'd43;
    localparam logic [PIX_W-1:0] OFS_RED    = 8'd0;
    localparam logic [PIX_W-1:0] OFS_GREEN  = 8'd85;
    localparam logic [PIX_W-1:0] OFS_BLUE   = 8'd171;

    // Working state of one restoring-division stage
    typedef struct packed {
        logic [PIX_W-1:0] rem;   // partial remainder
        logic [PIX_W-1:0] low;   // numerator bits not yet shifted in
        logic [PIX_W-1:0] quo;   // quotient bits so far
        logic [PIX_W-1:0] den;   // divisor
    } t_div_data;

    // Per-pixel side data that rides along with the divisions
    typedef struct packed {
        logic [PIX_W-1:0] hi;      // largest channel
        logic [PIX_W-1:0] offset;  // hue sector offset
        logic             neg;     // channel difference was negative
        logic             grey;    // max equals min: hue and sat are zero
    } t_meta;

endpackage

FILE: rtl/core/rgbhsv_div.sv
// Pipelined restoring divider: 16-bit numerator by 8-bit divisor, 8-bit quotient.
// Quotient must fit in 8 bits. Depends on rgbhsv_pkg.
module rgbhsv_div (
    input  logic                              i_clk,
    input  logic [rgbhsv_pkg::DIV_STAGES-1:0] i_adv,
    input  logic [rgbhsv_pkg::NUM_W-1:0]      i_num,
    input  logic [rgbhsv_pkg::PIX_W-1:0]      i_den,
    output logic [rgbhsv_pkg::PIX_W-1:0]      o_quo
);
    import rgbhsv_pkg::*;

    // BITS_PER_STAGE restoring steps, one quotient bit each
    function automatic t_div_data div_steps(t_div_data d_in);
        t_div_data      d;
        logic [PIX_W:0] cand;
        logic           qbit;
        d = d_in;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            cand  = {d.rem, d.low[PIX_W-1]};
            d.low = {d.low[PIX_W-2:0], 1'b0};
            qbit  = 1'b0;
            if (cand >= {1'b0, d.den}) begin
                cand = cand - {1'b0, d.den};
                qbit = 1'b1;
            end
            d.rem = cand[PIX_W-1:0];
            d.quo = {d.quo[PIX_W-2:0], qbit};
        end
        return d;
    endfunction

    t_div_data r_st  [DIV_STAGES];
    t_div_data w_src [DIV_STAGES];

    // Stage chain; upper numerator half seeds the remainder
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_src[s] = '{rem: i_num[NUM_W-1:PIX_W], low: i_num[PIX_W-1:0],
                                quo: '0, den: i_den};
        end else begin : g_next
            assign w_src[s] = r_st[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[s]) begin
                r_st[s] <= div_steps(w_src[s]);
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].quo;

endmodule

FILE: rtl/core/rgb_to_hsv_8bit_core.sv
// RGB to HSV conversion, 8 bits per channel, fully pipelined.
// Stages from input beat to output beat: sort, numerators, four divider
// stages at two quotient bits each, hue assembly. Throughput: one pixel per
// cycle while the output is not stalled; bubbles close up under output stall.
// Reset (synchronous, active low) clears only the stage valid bits.
// Depends on rgbhsv_pkg and rgbhsv_div.
module rgb_to_hsv_8bit_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_red,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_green,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_blue,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rgbhsv_pkg::PIX_W-1:0] o_hue,
    output logic [rgbhsv_pkg::PIX_W-1:0] o_saturation,
    output logic [rgbhsv_pkg::PIX_W-1:0] o_brightness
);
    import rgbhsv_pkg::*;

    localparam int NSTG  = DIV_STAGES + 3;
    localparam int DIV_0 = 2;

    // Stage valid bits and per-stage advance
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTG-1];

    // Stage 0: max, min, sector and channel difference
    logic [PIX_W-1:0]        w_hi, w_lo;
    logic [PIX_W-1:0]        w_ofs;
    logic signed [PIX_W:0]   w_diff;
    logic [PIX_W-1:0]        w_abs;

    always_comb begin
        w_hi = (i_red > i_green) ? i_red : i_green;
        w_hi = (w_hi > i_blue) ? w_hi : i_blue;
        w_lo = (i_red < i_green) ? i_red : i_green;
        w_lo = (w_lo < i_blue) ? w_lo : i_blue;
        // red wins ties, then green
        priority if (w_hi == i_red) begin
            w_ofs  = OFS_RED;
            w_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (w_hi == i_green) begin
            w_ofs  = OFS_GREEN;
            w_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            w_ofs  = OFS_BLUE;
            w_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        // magnitude always fits in 8 bits
        w_abs = w_diff[PIX_W] ? (~w_diff[PIX_W-1:0] + 1'b1) : w_diff[PIX_W-1:0];
    end

    logic [PIX_W-1:0] r0_span;
    logic [PIX_W-1:0] r0_abs;
    t_meta            r0_meta;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_span      <= w_hi - w_lo;
            r0_abs       <= w_abs;
            r0_meta.hi     <= w_hi;
            r0_meta.offset <= w_ofs;
            r0_meta.neg    <= w_diff[PIX_W];
            r0_meta.grey   <= (w_hi == w_lo);
        end
    end

    // Stage 1: divider numerators
    logic [NUM_W-1:0] r1_num_sat, r1_num_hue;
    logic [PIX_W-1:0] r1_span;
    t_meta            r_meta [DIV_0:NSTG-2];
    t_meta            r1_meta;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_num_sat <= {{PIX_W{1'b0}}, r0_span} * {{PIX_W{1'b0}}, SAT_SCALE};
            r1_num_hue <= {{PIX_W{1'b0}}, r0_abs} * {{PIX_W{1'b0}}, HUE_GAIN};
            r1_span    <= r0_span;
            r1_meta    <= r0_meta;
        end
    end

    // Stages 2..5: the two divisions run side by side
    logic [PIX_W-1:0] w_quo_sat, w_quo_hue;

    rgbhsv_div u_div_sat (
        .i_clk (i_clk),
        .i_adv (w_adv[DIV_0 +: DIV_STAGES]),
        .i_num (r1_num_sat),
        .i_den (r1_meta.hi),
        .o_quo (w_quo_sat)
    );

    rgbhsv_div u_div_hue (
        .i_clk (i_clk),
        .i_adv (w_adv[DIV_0 +: DIV_STAGES]),
        .i_num (r1_num_hue),
        .i_den (r1_span),
        .o_quo (w_quo_hue)
    );

    // Side data follows the divider stages
    always_ff @(posedge i_clk) begin
        if (w_adv[DIV_0]) begin
            r_meta[DIV_0] <= r1_meta;
        end
        for (int k = DIV_0 + 1; k <= NSTG - 2; k++) begin
            if (w_adv[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // Last stage: signed hue term plus offset, grey pixels get zero hue and saturation
    t_meta            w_m;
    logic [PIX_W-1:0] w_term;
    logic [PIX_W-1:0] r_hue, r_sat, r_bri;

    assign w_m    = r_meta[NSTG-2];
    assign w_term = w_m.neg ? (-w_quo_hue) : w_quo_hue;

    always_ff @(posedge i_clk) begin
        if (w_adv[NSTG-1]) begin
            r_hue <= w_m.grey ? '0 : (w_m.offset + w_term);
            r_sat <= w_m.grey ? '0 : w_quo_sat;
            r_bri <= w_m.hi;
        end
    end

    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bri;

endmodule
